FILE: sv/tpmc_pkg.sv
// Package for the trigger-poll MAC controller: beat types, codes and register map.
// Used by tpmc_cfg, tpmc_core and trigger_poll_mac_controller; depends on nothing.
package tpmc_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int TIMER_BITS = 24;
  localparam int CNT_BITS   = 32;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // Event codes on the input beat
  typedef enum logic [2:0] {
    FN_START    = 3'd0,
    FN_TICK     = 3'd1,
    FN_TRIG_END = 3'd2,
    FN_RX_START = 3'd3,
    FN_RX_END   = 3'd4
  } func_t;

  // Controller mode
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_TXTRIG = 3'd1,
    MODE_RXON   = 3'd2,
    MODE_RXOFF  = 3'd3,
    MODE_DATA   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_TRIG    = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_DROP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_CORRUPT   = 3'd1,
    RSN_WRONG_TYP = 3'd2,
    RSN_RX_OFF    = 3'd3,
    RSN_WRONG_RCV = 3'd4
  } reason_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_OWN_ADDR   = 2'd0,
    REG_BCAST_ADDR = 2'd1,
    REG_WINDOW     = 2'd2
  } reg_idx_t;

  localparam logic [ADDR_BITS-1:0]  OWN_ADDR_RST  = ADDR_BITS'(1);
  localparam logic [ADDR_BITS-1:0]  BCAST_RST     = ADDR_BITS'(65535);
  localparam logic [TIMER_BITS-1:0] WINDOW_RST    = TIMER_BITS'(1000);

  typedef struct packed {
    logic [2:0]           func;
    logic [ADDR_BITS-1:0] packet_dest;
    logic                 packet_corrupt;
    logic                 packet_is_trigger;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [2:0]          drop_reason;
    logic [2:0]          mode_now;
    logic                listening;
    logic [CNT_BITS-1:0] triggers_sent;
    logic [CNT_BITS-1:0] data_received;
    logic [CNT_BITS-1:0] errors_received;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  own_address;
    logic [ADDR_BITS-1:0]  broadcast_address;
    logic [TIMER_BITS-1:0] listen_window_ticks;
  } cfg_t;

endpackage

FILE: sv/tpmc_cfg.sv
// APB-style configuration registers of the trigger-poll MAC controller.
// Depends on tpmc_pkg for the register map and the cfg_t bundle.
module tpmc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpmc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpmc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpmc_pkg::PDATA_W-1:0]  prdata,
  output tpmc_pkg::cfg_t                cfg
);

  tpmc_pkg::cfg_t cfg_r;
  tpmc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        tpmc_pkg::REG_OWN_ADDR:   cfg_nxt.own_address = pwdata[tpmc_pkg::ADDR_BITS-1:0];
        tpmc_pkg::REG_BCAST_ADDR: cfg_nxt.broadcast_address = pwdata[tpmc_pkg::ADDR_BITS-1:0];
        tpmc_pkg::REG_WINDOW:
          cfg_nxt.listen_window_ticks = pwdata[tpmc_pkg::TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address         <= tpmc_pkg::OWN_ADDR_RST;
      cfg_r.broadcast_address   <= tpmc_pkg::BCAST_RST;
      cfg_r.listen_window_ticks <= tpmc_pkg::WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      tpmc_pkg::REG_OWN_ADDR:
        prdata = tpmc_pkg::PDATA_W'(cfg_r.own_address);
      tpmc_pkg::REG_BCAST_ADDR:
        prdata = tpmc_pkg::PDATA_W'(cfg_r.broadcast_address);
      tpmc_pkg::REG_WINDOW:
        prdata = tpmc_pkg::PDATA_W'(cfg_r.listen_window_ticks);
      default:
        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/tpmc_core.sv
// Event engine of the trigger-poll MAC controller: mode, listen window timer and counters.
// Depends on tpmc_pkg; fed one event beat per fire strobe by the top level.
module tpmc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  tpmc_pkg::in_item_t  item,
  input  tpmc_pkg::cfg_t      cfg,
  output tpmc_pkg::out_item_t result
);

  tpmc_pkg::mode_t                  mode_r, mode_nxt;
  logic                             listen_r, listen_nxt;
  logic [tpmc_pkg::TIMER_BITS-1:0]  win_left_r, win_left_nxt;
  logic                             win_run_r, win_run_nxt;
  logic [tpmc_pkg::CNT_BITS-1:0]    trig_cnt_r, trig_cnt_nxt;
  logic [tpmc_pkg::CNT_BITS-1:0]    data_cnt_r, data_cnt_nxt;
  logic [tpmc_pkg::CNT_BITS-1:0]    err_cnt_r, err_cnt_nxt;
  tpmc_pkg::action_t                action;
  tpmc_pkg::reason_t                reason;
  logic                             addr_hit;
  logic                             expire;

  assign addr_hit = (item.packet_dest == cfg.own_address) ||
                    (item.packet_dest == cfg.broadcast_address);
  assign expire   = (win_left_r <= tpmc_pkg::TIMER_BITS'(1));

  always_comb begin
    mode_nxt     = mode_r;
    listen_nxt   = listen_r;
    win_left_nxt = win_left_r;
    win_run_nxt  = win_run_r;
    trig_cnt_nxt = trig_cnt_r;
    data_cnt_nxt = data_cnt_r;
    err_cnt_nxt  = err_cnt_r;
    action       = tpmc_pkg::ACT_NONE;
    reason       = tpmc_pkg::RSN_NONE;
    unique case (item.func)
      tpmc_pkg::FN_START: begin
        win_run_nxt  = 1'b0;
        win_left_nxt = '0;
        mode_nxt     = tpmc_pkg::MODE_TXTRIG;
        if (!listen_r) begin
          trig_cnt_nxt = trig_cnt_r + 1'b1;
          action       = tpmc_pkg::ACT_TRIG;
        end
      end
      tpmc_pkg::FN_TICK: begin
        if (win_run_r) begin
          if (expire) begin
            win_left_nxt = '0;
            win_run_nxt  = 1'b0;
            // close the window and poll again at once, unless a trigger is on air
            if (mode_r != tpmc_pkg::MODE_TXTRIG) begin
              listen_nxt   = 1'b0;
              mode_nxt     = tpmc_pkg::MODE_TXTRIG;
              trig_cnt_nxt = trig_cnt_r + 1'b1;
              action       = tpmc_pkg::ACT_TRIG;
            end
          end else begin
            win_left_nxt = win_left_r - 1'b1;
          end
        end
      end
      tpmc_pkg::FN_TRIG_END: begin
        mode_nxt     = tpmc_pkg::MODE_RXON;
        win_left_nxt = cfg.listen_window_ticks;
        win_run_nxt  = 1'b1;
        listen_nxt   = 1'b1;
      end
      tpmc_pkg::FN_RX_END: begin
        if (!listen_r) begin
          action = tpmc_pkg::ACT_DROP;
          reason = tpmc_pkg::RSN_RX_OFF;
        end else if (item.packet_corrupt) begin
          err_cnt_nxt = err_cnt_r + 1'b1;
          action      = tpmc_pkg::ACT_DROP;
          reason      = tpmc_pkg::RSN_CORRUPT;
        end else if (addr_hit) begin
          if (!item.packet_is_trigger) begin
            mode_nxt     = tpmc_pkg::MODE_DATA;
            data_cnt_nxt = data_cnt_r + 1'b1;
            action       = tpmc_pkg::ACT_DELIVER;
          end else begin
            action = tpmc_pkg::ACT_DROP;
            reason = tpmc_pkg::RSN_WRONG_TYP;
          end
        end else begin
          action = tpmc_pkg::ACT_DROP;
          reason = tpmc_pkg::RSN_WRONG_RCV;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= tpmc_pkg::MODE_IDLE;
      listen_r   <= 1'b0;
      win_left_r <= '0;
      win_run_r  <= 1'b0;
      trig_cnt_r <= '0;
      data_cnt_r <= '0;
      err_cnt_r  <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      listen_r   <= listen_nxt;
      win_left_r <= win_left_nxt;
      win_run_r  <= win_run_nxt;
      trig_cnt_r <= trig_cnt_nxt;
      data_cnt_r <= data_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
    end
  end

  always_comb begin
    result.action          = action;
    result.drop_reason     = reason;
    result.mode_now        = mode_nxt;
    result.listening       = listen_nxt;
    result.triggers_sent   = trig_cnt_nxt;
    result.data_received   = data_cnt_nxt;
    result.errors_received = err_cnt_nxt;
  end

  // a stopped timer always holds zero
  a_idle_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !win_run_r |-> (win_left_r == '0))
    else $error("window timer stopped with ticks left");

  // a trigger beat bumps the trigger counter by exactly one
  a_trig_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (action == tpmc_pkg::ACT_TRIG)) |=> (trig_cnt_r == $past(trig_cnt_r) + 1'b1))
    else $error("trigger sent without counting it");

endmodule

FILE: sv/trigger_poll_mac_controller.sv
// Trigger-poll MAC controller, top level: input register, event engine, result register, APB.
// A beat passes through two registers, the input register and then the result register, to out_*.
// Throughput: one event beat per clock while the result is not stalled.
// A stalled result holds the output register; the input register then holds and in_stall rises.
// Reset (rst_n low, synchronous): both stages empty, mode idle, window shut, counters zero,
// registers back to own address 1, broadcast address 0xFFFF and a 1000-tick window.
module trigger_poll_mac_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tpmc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tpmc_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tpmc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [tpmc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [tpmc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  // input stage
  logic                 s1_valid_r, s1_valid_nxt;
  tpmc_pkg::in_item_t   s1_data_r;
  // result stage
  logic                 out_valid_r, out_valid_nxt;
  tpmc_pkg::out_item_t  out_data_r;

  tpmc_pkg::cfg_t       cfg;
  tpmc_pkg::out_item_t  core_res;
  logic                 out_free;
  logic                 fire;
  logic                 in_take;

  // The result register can load when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // Fire the event engine whenever the input stage holds a beat and the result has room.
  assign fire     = s1_valid_r && out_free;
  // Hold the input side only while a beat waits behind a stalled result.
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on the beat that fills them, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= core_res;
    end
  end

  tpmc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  tpmc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (core_res)
  );

  assign cfg_pready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // backpressure only ever comes from a full input stage
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  // a drop reason is shown exactly on drop beats
  a_reason_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.action == tpmc_pkg::ACT_DROP) ==
                     (out_data_r.drop_reason != tpmc_pkg::RSN_NONE)))
    else $error("drop reason does not match action");

  // an open window never reports idle or receive-off
  a_listen_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.listening) |->
      ((out_data_r.mode_now != tpmc_pkg::MODE_IDLE) &&
       (out_data_r.mode_now != tpmc_pkg::MODE_RXOFF)))
    else $error("listening in a mode that cannot listen");

endmodule

FILE: bench/trigger_poll_mac_controller_tb.sv
// Self-checking bench for trigger_poll_mac_controller: directed and random event beats,
// an in-bench model of the polling MAC, APB register writes between phases.
// Depends on tpmc_pkg and the RTL top level only.
module trigger_poll_mac_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 315;
  localparam int HOLD_LEN    = 400;
  localparam int FUNC_CODES  = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]   cfg_paddr = '0;
  logic [PDATA_W-1:0]   cfg_pwdata = '0;
  logic [PDATA_W-1:0]   cfg_prdata;
  logic                 cfg_pready;

  // Beats waiting to be offered, and MAC responses still owed by the block
  in_item_t  event_q[$];
  out_item_t response_q[$];

  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Idling percentages, changed per phase
  int unsigned send_gap_pct = 23;
  int unsigned stall_pct = 71;

  // Long receiver hold-off: each bump of hold_req starts one stretch
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Model of the controller: registers and state
  logic [ADDR_BITS-1:0]  own_addr   = OWN_ADDR_RST;
  logic [ADDR_BITS-1:0]  bcast_addr = BCAST_RST;
  logic [TIMER_BITS-1:0] win_len    = WINDOW_RST;

  mode_t                 mode = MODE_IDLE;
  logic                  listen_on = 1'b0;
  logic [TIMER_BITS-1:0] win_left = '0;
  logic                  win_run = 1'b0;
  logic [CNT_BITS-1:0]   trig_cnt = '0;
  logic [CNT_BITS-1:0]   data_cnt = '0;
  logic [CNT_BITS-1:0]   err_cnt = '0;

  trigger_poll_mac_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fault_cnt++;
  endtask

  // Cancel the listen timer and try to send a trigger; a trigger is
  // withheld while the receive window is still open.
  function automatic action_t start_poll();
    win_run = 1'b0;
    win_left = '0;
    mode = MODE_TXTRIG;
    if (!listen_on) begin
      trig_cnt = trig_cnt + 1;
      return ACT_TRIG;
    end
    return ACT_NONE;
  endfunction

  // Advance the controller by one event and return the response it owes.
  function automatic out_item_t mac_response(in_item_t ev);
    out_item_t r;
    action_t   act;
    reason_t   rsn;
    act = ACT_NONE;
    rsn = RSN_NONE;
    case (ev.func)
      FN_START: begin
        act = start_poll();
      end
      FN_TICK: begin
        // a tick with no timer running does nothing
        if (win_run) begin
          if (win_left <= 1) begin
            win_left = '0;
            win_run = 1'b0;
            // expiry while sending a trigger only stops the timer
            if (mode != MODE_TXTRIG) begin
              mode = MODE_RXOFF;
              listen_on = 1'b0;
              act = start_poll();
            end
          end else begin
            win_left = win_left - 1;
          end
        end
      end
      FN_TRIG_END: begin
        // a zero-length window expires on the first tick, same as one tick
        mode = MODE_RXON;
        win_left = win_len;
        win_run = 1'b1;
        listen_on = 1'b1;
      end
      FN_RX_END: begin
        act = ACT_DROP;
        if (!listen_on) begin
          rsn = RSN_RX_OFF;
        end else if (ev.packet_corrupt) begin
          // corrupt wins over address and type
          err_cnt = err_cnt + 1;
          rsn = RSN_CORRUPT;
        end else if (ev.packet_dest == own_addr || ev.packet_dest == bcast_addr) begin
          if (!ev.packet_is_trigger) begin
            mode = MODE_DATA;
            data_cnt = data_cnt + 1;
            act = ACT_DELIVER;
          end else begin
            rsn = RSN_WRONG_TYP;
          end
        end else begin
          rsn = RSN_WRONG_RCV;
        end
      end
      default: begin
        // rx start and the unused codes leave everything alone
      end
    endcase
    r.action          = act;
    r.drop_reason     = rsn;
    r.mode_now        = mode;
    r.listening       = listen_on;
    r.triggers_sent   = trig_cnt;
    r.data_received   = data_cnt;
    r.errors_received = err_cnt;
    return r;
  endfunction

  // Sender: offer queued beats, idling at random; hold the beat while stalled.
  always @(posedge clk) begin : feed
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        response_q.push_back(mac_response(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Count down a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_req) begin
      hold_left <= HOLD_LEN;
      hold_seen <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each accepted result beat against the oldest response owed,
  // then choose the next stall.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (response_q.size() == 0) begin
          report_mismatch("result beat with no response owed");
        end else begin
          want = response_q.pop_front();
          if (out_data.action !== want.action)
            report_mismatch($sformatf("action got %0d want %0d",
                                      out_data.action, want.action));
          if (out_data.drop_reason !== want.drop_reason)
            report_mismatch($sformatf("drop_reason got %0d want %0d",
                                      out_data.drop_reason, want.drop_reason));
          if (out_data.mode_now !== want.mode_now)
            report_mismatch($sformatf("mode_now got %0d want %0d",
                                      out_data.mode_now, want.mode_now));
          if (out_data.listening !== want.listening)
            report_mismatch($sformatf("listening got %0d want %0d",
                                      out_data.listening, want.listening));
          if (out_data.triggers_sent !== want.triggers_sent)
            report_mismatch($sformatf("triggers_sent got %0d want %0d",
                                      out_data.triggers_sent, want.triggers_sent));
          if (out_data.data_received !== want.data_received)
            report_mismatch($sformatf("data_received got %0d want %0d",
                                      out_data.data_received, want.data_received));
          if (out_data.errors_received !== want.errors_received)
            report_mismatch($sformatf("errors_received got %0d want %0d",
                                      out_data.errors_received, want.errors_received));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // APB write: setup cycle, then access until pready; mirror into the model.
  task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_OWN_ADDR:   own_addr = val[ADDR_BITS-1:0];
      REG_BCAST_ADDR: bcast_addr = val[ADDR_BITS-1:0];
      REG_WINDOW:     win_len = val[TIMER_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold until every beat is accepted and every response has come back
  task automatic wait_idle();
    while (event_q.size() != 0 || in_valid || response_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_event(logic [2:0] f, logic [ADDR_BITS-1:0] dest, logic corrupt,
                            logic is_trig);
    in_item_t ev;
    ev.func = f;
    ev.packet_dest = dest;
    ev.packet_corrupt = corrupt;
    ev.packet_is_trigger = is_trig;
    event_q.push_back(ev);
  endtask

  // Non-packet event; the packet fields carry junk that must be ignored
  task automatic push_plain(func_t f);
    push_event(f, ADDR_BITS'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic push_noise();
    push_event(3'($urandom_range(FUNC_CODES - 1)), ADDR_BITS'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_dest();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return own_addr;
    if (p < 65) return bcast_addr;
    return ADDR_BITS'($urandom);
  endfunction

  // A received packet: rx start then rx end with mostly well-aimed content
  task automatic push_packet();
    push_plain(FN_RX_START);
    push_event(FN_RX_END, pick_dest(), $urandom_range(99) < 20, $urandom_range(99) < 30);
  endtask

  // One polling round: start, trigger sent, then traffic and ticks in the window
  task automatic gen_round(int unsigned win);
    int unsigned n;
    int unsigned p;
    push_plain(FN_START);
    push_plain(FN_TRIG_END);
    n = $urandom_range(1, (win < 12) ? 2 * win + 3 : 30);
    repeat (n) begin
      p = $urandom_range(99);
      if (p < 45) push_plain(FN_TICK);
      else if (p < 80) push_packet();
      else if (p < 85) push_plain(FN_START);
      else if (p < 92) push_plain(FN_TRIG_END);
      else push_noise();
    end
  endtask

  task automatic run_phase(logic [ADDR_BITS-1:0] own, logic [ADDR_BITS-1:0] bcast,
                           logic [TIMER_BITS-1:0] win, int unsigned gap,
                           int unsigned stall, bit squeeze);
    wait_idle();
    cfg_write(REG_OWN_ADDR, PDATA_W'(own));
    cfg_write(REG_BCAST_ADDR, PDATA_W'(bcast));
    cfg_write(REG_WINDOW, PDATA_W'(win));
    send_gap_pct <= gap;
    stall_pct <= stall;
    // squeeze: receiver holds off while the sender keeps offering
    if (squeeze) hold_req <= hold_req + 1;
    while (event_q.size() < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 6)) push_noise();
      else gen_round(win);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    logic [ADDR_BITS-1:0] a;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset registers: own 1, broadcast all ones, 1000-tick window
    push_event(FN_RX_END, OWN_ADDR_RST, 1'b0, 1'b0);     // receiver off
    push_plain(FN_START);                                // trigger
    push_plain(FN_START);                                // trigger again, not listening
    push_plain(FN_TRIG_END);                             // open window
    push_plain(FN_RX_START);
    push_event(FN_RX_END, OWN_ADDR_RST, 1'b1, 1'b0);     // corrupt
    push_event(FN_RX_END, OWN_ADDR_RST, 1'b0, 1'b0);     // deliver
    push_event(FN_RX_END, BCAST_RST, 1'b0, 1'b1);        // trigger type
    push_event(FN_RX_END, '0, 1'b0, 1'b0);               // someone else's
    push_event(FN_RX_END, '0, 1'b1, 1'b1);               // corrupt beats the rest
    push_plain(FN_TICK);
    push_plain(FN_START);                                // start while listening
    push_plain(FN_TICK);                                 // timer cancelled
    for (int f = int'(FN_RX_END) + 1; f < FUNC_CODES; f++)
      push_event(3'(f), ADDR_BITS'($urandom), 1'($urandom), 1'($urandom));
    push_plain(FN_TRIG_END);
    wait_idle();

    // Directed, zero-length window and address extremes
    cfg_write(REG_OWN_ADDR, '0);
    cfg_write(REG_WINDOW, '0);
    push_plain(FN_TICK);                                 // old window still long
    push_plain(FN_TRIG_END);
    push_event(FN_RX_END, '0, 1'b0, 1'b0);
    push_event(FN_RX_END, '1, 1'b0, 1'b0);
    push_plain(FN_TICK);                                 // zero acts as one tick
    wait_idle();

    // Random phases: heavy receiver stalls, then heavy sender gaps, then flat out, each twice
    run_phase('0, '1, TIMER_BITS'(1), 23, 71, 1'b0);
    run_phase('1, '0, TIMER_BITS'(5), 71, 23, 1'b0);
    run_phase(ADDR_BITS'($urandom), ADDR_BITS'($urandom), TIMER_BITS'(4), 0, 0, 1'b1);
    a = ADDR_BITS'($urandom);
    run_phase(a, a, TIMER_BITS'(3), 23, 71, 1'b0);
    run_phase(ADDR_BITS'($urandom), ADDR_BITS'($urandom),
              TIMER_BITS'($urandom_range(2, 12)), 71, 23, 1'b0);
    run_phase(ADDR_BITS'(16'h8000), ADDR_BITS'(16'h7FFF), '1, 0, 0, 1'b0);

    // Let the two pipeline stages settle before judging
    wait_idle();
    repeat (8) @(posedge clk);
    if (fault_cnt == 0 && response_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
